>>> rtl/bdasc_pkg.sv
// ----------------------------------------------------------------------------
// bdasc_pkg - shared types and constants for the decimal text converter
// Controller state, datapath command and status groups, and ASCII codes.
// ----------------------------------------------------------------------------
package bdasc_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CHAR_W = 8;

  localparam logic [CFG_W-1:0]  BUFFER_SIZE_RST = 16'd21;
  localparam logic [CFG_W-1:0]  SMALL_BUF_MAX   = 16'd2;
  localparam logic [CHAR_W-1:0] ASCII_ZERO      = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE      = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_NUL       = 8'd0;
  localparam logic [3:0]        DABBLE_THRESH   = 4'd5;
  localparam logic [3:0]        DABBLE_ADJ      = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_EMIT,
    ST_TERM,
    ST_ZERO_DIGIT,
    ST_ERROR
  } state_e;

  typedef enum logic [1:0] {
    OUT_DIGIT,
    OUT_ZERO_CHAR,
    OUT_TERM,
    OUT_ERR
  } out_kind_e;

  typedef struct packed {
    logic      load;
    logic      dabble;
    logic      shift_digit;
    logic      push;
    out_kind_e out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_zero;
    logic bits_done;
    logic top_zero;
    logic digits_empty;
    logic limit_hit;
    logic small_buf;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/bdasc_ctrl.sv
// ----------------------------------------------------------------------------
// bdasc_ctrl - conversion sequencer
// Steps through bit conversion, leading zero skip and character output.
// ----------------------------------------------------------------------------
module bdasc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bdasc_pkg::ctrl_sts_t sts_i,
  output bdasc_pkg::ctrl_cmd_t cmd_o
);

  bdasc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdasc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    in_ready_o        = 1'b0;
    cmd_o.load        = 1'b0;
    cmd_o.dabble      = 1'b0;
    cmd_o.shift_digit = 1'b0;
    cmd_o.push        = 1'b0;
    cmd_o.out_kind    = bdasc_pkg::OUT_DIGIT;
    unique case (state_q)
      bdasc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (!sts_i.in_zero) begin
            state_d = bdasc_pkg::ST_CONVERT;
          end else if (sts_i.small_buf) begin
            state_d = bdasc_pkg::ST_ERROR;
          end else begin
            state_d = bdasc_pkg::ST_ZERO_DIGIT;
          end
        end
      end
      bdasc_pkg::ST_CONVERT: begin
        cmd_o.dabble = 1'b1;
        if (sts_i.bits_done) begin
          state_d = bdasc_pkg::ST_SKIP;
        end
      end
      bdasc_pkg::ST_SKIP: begin
        if (sts_i.top_zero) begin
          cmd_o.shift_digit = 1'b1;
        end else begin
          state_d = bdasc_pkg::ST_EMIT;
        end
      end
      bdasc_pkg::ST_EMIT: begin
        priority if (sts_i.digits_empty || sts_i.limit_hit) begin
          state_d = bdasc_pkg::ST_TERM;
        end else if (sts_i.out_free) begin
          cmd_o.push        = 1'b1;
          cmd_o.shift_digit = 1'b1;
        end else begin
          state_d = bdasc_pkg::ST_EMIT;
        end
      end
      bdasc_pkg::ST_TERM: begin
        cmd_o.out_kind = bdasc_pkg::OUT_TERM;
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = bdasc_pkg::ST_IDLE;
        end
      end
      bdasc_pkg::ST_ZERO_DIGIT: begin
        cmd_o.out_kind = bdasc_pkg::OUT_ZERO_CHAR;
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = bdasc_pkg::ST_TERM;
        end
      end
      bdasc_pkg::ST_ERROR: begin
        cmd_o.out_kind = bdasc_pkg::OUT_ERR;
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = bdasc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bdasc_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> sts_i.out_free)
    else $error("item pushed into occupied output register");

  a_skip_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bdasc_pkg::ST_SKIP && !sts_i.top_zero) |=> state_q == bdasc_pkg::ST_EMIT)
    else $error("skip did not hand over to emit");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == bdasc_pkg::ST_IDLE)
    else $error("input accepted outside idle");
`endif

endmodule

>>> rtl/bdasc_dp.sv
// ----------------------------------------------------------------------------
// bdasc_dp - shift-add-3 datapath with digit emission and output register
// Holds the value, the BCD digits, the counters and the buffer size register.
// ----------------------------------------------------------------------------
module bdasc_dp #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [63:0]                   in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [bdasc_pkg::CFG_W-1:0]   cfg_data_i,
  input  bdasc_pkg::ctrl_cmd_t          cmd_i,
  output bdasc_pkg::ctrl_sts_t          sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bdasc_pkg::CHAR_W-1:0]  out_char_o,
  output logic                          out_last_o,
  output logic                          out_err_o
);

  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  logic [VALUE_BITS-1:0]         value_q, value_d;
  logic [BCD_W-1:0]              bcd_q, bcd_d, bcd_adj;
  logic [BIT_CNT_W-1:0]          bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]          dig_left_q, dig_left_d;
  logic [DIG_CNT_W-1:0]          emit_cnt_q, emit_cnt_d;
  logic [bdasc_pkg::CFG_W-1:0]   buf_size_q;
  logic                          out_valid_q;
  logic [bdasc_pkg::CHAR_W-1:0]  out_char_q;
  logic                          out_last_q;
  logic                          out_err_q;
  logic [3:0]                    top_digit;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  always_comb begin
    for (int i = 0; i < int'(NUM_DIGITS); i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= bdasc_pkg::DABBLE_THRESH) ?
                          bcd_q[4*i +: 4] + bdasc_pkg::DABBLE_ADJ : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    value_d    = value_q;
    bcd_d      = bcd_q;
    bit_cnt_d  = bit_cnt_q;
    dig_left_d = dig_left_q;
    emit_cnt_d = emit_cnt_q;
    if (cmd_i.load) begin
      value_d    = in_data_i[VALUE_BITS-1:0];
      bcd_d      = '0;
      bit_cnt_d  = '0;
      dig_left_d = DIG_CNT_W'(NUM_DIGITS);
      emit_cnt_d = '0;
    end else if (cmd_i.dabble) begin
      value_d   = {value_q[VALUE_BITS-2:0], 1'b0};
      bcd_d     = {bcd_adj[BCD_W-2:0], value_q[VALUE_BITS-1]};
      bit_cnt_d = bit_cnt_q + 1'b1;
    end else if (cmd_i.shift_digit) begin
      bcd_d      = {bcd_q[BCD_W-5:0], 4'd0};
      dig_left_d = dig_left_q - 1'b1;
      if (cmd_i.push) begin
        emit_cnt_d = emit_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    bcd_q   <= bcd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q  <= '0;
      dig_left_q <= '0;
      emit_cnt_q <= '0;
      buf_size_q <= bdasc_pkg::BUFFER_SIZE_RST;
    end else begin
      bit_cnt_q  <= bit_cnt_d;
      dig_left_q <= dig_left_d;
      emit_cnt_q <= emit_cnt_d;
      if (cfg_valid_i) begin
        buf_size_q <= cfg_data_i;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      unique case (cmd_i.out_kind)
        bdasc_pkg::OUT_DIGIT: begin
          out_char_q <= bdasc_pkg::ASCII_ZERO + {4'd0, top_digit};
          out_last_q <= 1'b0;
          out_err_q  <= 1'b0;
        end
        bdasc_pkg::OUT_ZERO_CHAR: begin
          out_char_q <= bdasc_pkg::ASCII_ZERO;
          out_last_q <= 1'b0;
          out_err_q  <= 1'b0;
        end
        bdasc_pkg::OUT_TERM: begin
          out_char_q <= bdasc_pkg::ASCII_NUL;
          out_last_q <= 1'b1;
          out_err_q  <= 1'b0;
        end
        default: begin
          out_char_q <= bdasc_pkg::ASCII_NUL;
          out_last_q <= 1'b1;
          out_err_q  <= 1'b1;
        end
      endcase
    end
  end

  assign sts_o.in_zero      = (in_data_i[VALUE_BITS-1:0] == '0);
  assign sts_o.bits_done    = (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1));
  assign sts_o.top_zero     = (top_digit == 4'd0);
  assign sts_o.digits_empty = (dig_left_q == '0);
  assign sts_o.limit_hit    = (buf_size_q != '0) &&
                              ({{(bdasc_pkg::CFG_W-DIG_CNT_W){1'b0}}, emit_cnt_q} >=
                               (buf_size_q - 16'd1));
  assign sts_o.small_buf    = (buf_size_q <= bdasc_pkg::SMALL_BUF_MAX);
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

`ifndef SYNTHESIS
  a_digit_available: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push && cmd_i.out_kind == bdasc_pkg::OUT_DIGIT) |-> !sts_o.digits_empty)
    else $error("digit emitted with none left");

  a_digit_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |->
      (out_char_q >= bdasc_pkg::ASCII_ZERO && out_char_q <= bdasc_pkg::ASCII_NINE))
    else $error("non-final item is not a decimal digit");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_last_q && out_char_q == bdasc_pkg::ASCII_NUL))
    else $error("error item not a final nul");
`endif

endmodule

>>> rtl/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core - unsigned binary to decimal ASCII text
// Converts each input value to digits, most significant first, then a nul.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one item per value, tdata carries the value (low VALUE_BITS used).
//   m_axis: one item per character; tlast marks the terminating nul or the
//     error item, tuser is the error flag.
//   cfg: write buffer_size (terminator included) while the block is idle.
// Sequence
//   A nonzero value is accepted, runs through the shift-add-3 loop once per
//   value bit, drops its leading zero digits, and emits its characters and
//   then the terminator; digits beyond the buffer size are not emitted. A
//   zero value emits one zero character and the terminator, or only the error
//   item when buffer_size is 2 or less. s_axis_tready is high only between
//   conversions.
// Reset
//   Sequencer returns to idle, output register empties, buffer_size is 21.
// Stall
//   A stalled receiver holds the current item in the output register and the
//   sequencer waits; no item is lost or repeated.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] character
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] error
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // buffer_size
);

  bdasc_pkg::ctrl_cmd_t cmd;
  bdasc_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bdasc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bdasc_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule
